// ===== design/hcm_pkg.sv =====
package hcm_pkg;

    // Field widths fixed by the interface.
    localparam int HEIGHT_W   = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int DIFF_W     = HEIGHT_W + 1;
    localparam int FRAC_W     = 40;
    localparam int CHAN_W     = 8;

    localparam logic [CFG_DATA_W-1:0] LOW_EDGE_RESET     = 32'd0;
    localparam logic [CFG_DATA_W-1:0] INVERSE_SPAN_RESET = 32'd335544;

    // Angle constants are Q2.30; the turn constants are FRAC_W-bit fractions.
    localparam logic [FRAC_W-1:0]  HALF_TURN   = 40'h80_0000_0000;
    localparam logic [FRAC_W:0]    FULL_TURN   = 41'h100_0000_0000;
    localparam longint             Q30_ONE     = 64'sd1073741824;
    localparam longint             ANGLE_BASE  = 64'sd1011464798;
    localparam longint unsigned    ANGLE_SLOPE = 64'd4720169058;
    localparam longint             HALF_PI_Q30 = 64'sd1686629713;
    localparam int                 SERIES_TERMS = 8;

    // Factorial step divisors of the sine and cosine series.
    localparam longint unsigned SIN_DIV [SERIES_TERMS] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272};
    localparam longint unsigned COS_DIV [SERIES_TERMS] =
        '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_EDGE     = 1'b0,
        REG_INVERSE_SPAN = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } color_t;

    // Pipeline control passed to each stage group.
    typedef struct packed {
        logic advance;
        logic valid;
    } pipe_ctrl_t;

    function automatic longint sin_mag(input longint unsigned ax);
        longint unsigned term;
        longint          acc;
        term = ax;
        acc  = longint'(ax);
        for (int k = 0; k < SERIES_TERMS; k++)
        begin
            term = (term * ax) >> 30;
            term = (term * ax) >> 30;
            term = term / SIN_DIV[k];
            if ((k % 2) == 0)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        return acc;
    endfunction

    function automatic longint cos_mag(input longint unsigned ax);
        longint unsigned term;
        longint          acc;
        term = longint'(Q30_ONE);
        acc  = Q30_ONE;
        for (int k = 0; k < SERIES_TERMS; k++)
        begin
            term = (term * ax) >> 30;
            term = (term * ax) >> 30;
            term = term / COS_DIV[k];
            if ((k % 2) == 0)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        return acc;
    endfunction

    function automatic logic [CHAN_W-1:0] channel(input longint s);
        longint v;
        longint q;
        v = 64'sd127 * Q30_ONE + 64'sd128 * s;
        if (v < 0)
            return '0;
        q = v >>> 30;
        if (q > 64'sd255)
            return 8'd255;
        return q[CHAN_W-1:0];
    endfunction

    // Colour for one phase index; evaluated only while the table is built.
    function automatic color_t color_entry(input int unsigned idx,
                                           input int unsigned phase_bits);
        longint angle;
        longint x;
        longint unsigned ax;
        longint sn;
        longint cs;
        color_t c;
        angle = ANGLE_BASE + longint'((ANGLE_SLOPE * longint'(idx)) >> phase_bits);
        x     = angle - HALF_PI_Q30;
        ax    = (x < 0) ? longint'(-x) : longint'(x);
        sn    = cos_mag(ax);
        cs    = sin_mag(ax);
        if (x >= 0)
            cs = -cs;
        c.red   = channel(sn);
        c.green = channel(cs);
        c.blue  = channel(-sn);
        return c;
    endfunction

endpackage

// ===== design/hcm_phase.sv =====
module hcm_phase
    import hcm_pkg::*;
#(
    parameter int PHASE_BITS = 10
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  pipe_ctrl_t              ctrl,
    input  logic [HEIGHT_W-1:0]     height,
    input  logic [CFG_DATA_W-1:0]   low_edge,
    input  logic [CFG_DATA_W-1:0]   inverse_span,
    output logic                    idx_valid,
    output logic [PHASE_BITS-1:0]   idx
);

    localparam logic [PHASE_BITS-1:0] IDX_MAX = PHASE_BITS'(1) << (PHASE_BITS - 1);

    logic signed [DIFF_W-1:0]   diff_reg,  diff_next;
    logic [FRAC_W-1:0]          frac_reg,  frac_next;
    logic [PHASE_BITS-1:0]      idx_reg,   idx_next;
    logic                       v1_reg, v2_reg, v3_reg;
    logic signed [2*DIFF_W-1:0] product;
    logic [FRAC_W-1:0]          mirrored;

    // Stage one: exact difference from the lower edge.
    assign diff_next = $signed({height[HEIGHT_W-1], height})
                     - $signed({low_edge[CFG_DATA_W-1], low_edge});

    // Stage two: scale; only the fractional bits survive.
    assign product   = diff_reg * $signed({1'b0, inverse_span});
    assign frac_next = product[FRAC_W-1:0];

    // Stage three: fold the upper half back and quantise.
    assign mirrored = (frac_reg > HALF_TURN)
                    ? FRAC_W'(FULL_TURN - {1'b0, frac_reg})
                    : frac_reg;
    assign idx_next = mirrored[FRAC_W-1 -: PHASE_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            v1_reg <= ctrl.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            diff_reg <= diff_next;
            frac_reg <= frac_next;
            idx_reg  <= idx_next;
        end
    end

    assign idx_valid = v3_reg;
    assign idx       = idx_reg;

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> (idx_reg <= IDX_MAX))
        else $error("phase index beyond the folded half");

endmodule

// ===== design/hcm_color_rom.sv =====
module hcm_color_rom
    import hcm_pkg::*;
#(
    parameter int PHASE_BITS = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pipe_ctrl_t            ctrl,
    input  logic [PHASE_BITS-1:0] idx,
    output logic                  color_valid,
    output color_t                color
);

    localparam int ROM_DEPTH = (1 << (PHASE_BITS - 1)) + 1;

    color_t rom_entry [ROM_DEPTH];
    color_t color_reg;
    logic   valid_reg;

    for (genvar g = 0; g < ROM_DEPTH; g++)
    begin : g_rom
        localparam color_t ENTRY = color_entry(g, PHASE_BITS);
        assign rom_entry[g] = ENTRY;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ctrl.advance)
            valid_reg <= ctrl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
            color_reg <= rom_entry[idx];
    end

    assign color_valid = valid_reg;
    assign color       = color_reg;

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!ctrl.advance && valid_reg) |=> (valid_reg && $stable(color_reg)))
        else $error("colour register changed while the pipeline was held");

endmodule

// ===== design/height_to_color_map.sv =====
// Channel  | Direction | Handshake          | Payload
// request  | in        | in_valid/in_stall  | height (signed Q16.16)
// result   | out       | out_valid/out_stall| red, green, blue (8 bit each)
// config   | in        | write_enable       | write_index, write_data
//
// One request can be accepted in every cycle unless a result is stalled at
// the output, and its colour reaches the outputs through the stages below.
// The four register stages are the edge difference, the scaling multiplier,
// the mirror and quantise step, and the registered colour table read.
// Reset clears every valid bit and loads the default range registers.
// A stalled result holds every stage, so in_stall follows out_stall while a
// result waits; no stage moves during the hold, empty ones included.
module height_to_color_map
    import hcm_pkg::*;
#(
    parameter int PHASE_BITS = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [HEIGHT_W-1:0]   height,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [CHAN_W-1:0]     red,
    output logic [CHAN_W-1:0]     green,
    output logic [CHAN_W-1:0]     blue,
    input  logic                  write_enable,
    input  logic [CFG_IDX_W-1:0]  write_index,
    input  logic [CFG_DATA_W-1:0] write_data
);

    logic [CFG_DATA_W-1:0] low_edge_reg,     low_edge_next;
    logic [CFG_DATA_W-1:0] inverse_span_reg, inverse_span_next;

    logic                  advance;
    pipe_ctrl_t            phase_ctrl;
    pipe_ctrl_t            rom_ctrl;
    logic                  idx_valid;
    logic [PHASE_BITS-1:0] idx;
    color_t                color;

    // The whole pipeline moves together unless a finished colour is held
    // at the output; bubbles are overwritten when the output is empty.
    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    assign phase_ctrl = '{advance: advance, valid: in_valid};
    assign rom_ctrl   = '{advance: advance, valid: idx_valid};

    // Register writes must arrive only while the pipeline is idle; the block does not enforce it.
    always_comb
    begin
        low_edge_next     = low_edge_reg;
        inverse_span_next = inverse_span_reg;
        if (write_enable)
        begin
            unique case (cfg_reg_t'(write_index))
                REG_LOW_EDGE:     low_edge_next     = write_data;
                REG_INVERSE_SPAN: inverse_span_next = write_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_edge_reg     <= LOW_EDGE_RESET;
            inverse_span_reg <= INVERSE_SPAN_RESET;
        end
        else
        begin
            low_edge_reg     <= low_edge_next;
            inverse_span_reg <= inverse_span_next;
        end
    end

    hcm_phase #(
        .PHASE_BITS (PHASE_BITS)
    ) u_phase (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (phase_ctrl),
        .height       (height),
        .low_edge     (low_edge_reg),
        .inverse_span (inverse_span_reg),
        .idx_valid    (idx_valid),
        .idx          (idx)
    );

    hcm_color_rom #(
        .PHASE_BITS (PHASE_BITS)
    ) u_color_rom (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (rom_ctrl),
        .idx         (idx),
        .color_valid (out_valid),
        .color       (color)
    );

    assign red   = color.red;
    assign green = color.green;
    assign blue  = color.blue;

    // A request that meets no hold on its way through the stages reaches the output.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !in_stall ##1 !in_stall ##1 !in_stall
        |=> out_valid)
        else $error("request lost in the pipeline");

    // Input is held back only while a result waits at the output.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a waiting result");

endmodule

// ===== tb/color_map_checker.sv =====
`timescale 1ns / 100ps

module color_map_checker
    import hcm_pkg::*;
#(
    parameter int PHASE_BITS = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [HEIGHT_W-1:0]   height,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [CHAN_W-1:0]     red,
    input  logic [CHAN_W-1:0]     green,
    input  logic [CHAN_W-1:0]     blue,
    input  logic                  write_enable,
    input  logic [CFG_IDX_W-1:0]  write_index,
    input  logic [CFG_DATA_W-1:0] write_data,
    output int                    fail_count,
    output int                    pending_results
);

    // Angles are Q2.30: 0.3*3.14, 1.4*3.14 and pi/2.
    localparam longint          UNIT_Q30     = 64'sd1073741824;
    localparam longint          ANGLE_START  = 64'sd1011464798;
    localparam longint unsigned ANGLE_GAIN   = 64'd4720169058;
    localparam longint          QUARTER_TURN = 64'sd1686629713;

    logic [CFG_DATA_W-1:0] low_edge_q     = LOW_EDGE_RESET;
    logic [CFG_DATA_W-1:0] inverse_span_q = INVERSE_SPAN_RESET;
    color_t                expected_colors [$];
    int                    errors_seen = 0;
    int                    outstanding = 0;

    assign fail_count      = errors_seen;
    assign pending_results = outstanding;

    // Truncated Taylor sum in Q30, eight terms after the first; odd powers give
    // the sine, even powers the cosine.
    function automatic longint taylor_sum(input longint unsigned ax, input bit odd_powers);
        longint unsigned term;
        longint unsigned div;
        longint          acc;
        term = odd_powers ? ax : longint'(UNIT_Q30);
        acc  = longint'(term);
        for (int k = 1; k <= 8; k++)
        begin
            div  = odd_powers ? 64'(2 * k * (2 * k + 1)) : 64'(2 * k * (2 * k - 1));
            term = (term * ax) >> 30;
            term = (term * ax) >> 30;
            term = term / div;
            if (k % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        return acc;
    endfunction

    function automatic logic [CHAN_W-1:0] to_channel(input longint s);
        longint level;
        level = 64'sd127 * UNIT_Q30 + 64'sd128 * s;
        if (level < 0)
            return '0;
        if ((level >>> 30) > 64'sd255)
            return 8'd255;
        return CHAN_W'(level >>> 30);
    endfunction

    function automatic color_t predict_color(input logic [HEIGHT_W-1:0]   h,
                                             input logic [CFG_DATA_W-1:0] lo,
                                             input logic [CFG_DATA_W-1:0] span);
        logic signed [32:0] diff;
        logic [63:0]        prod;
        logic [39:0]        t;
        logic [39:0]        m;
        longint unsigned    idx;
        longint unsigned    ax;
        longint             angle;
        longint             x;
        longint             sin_val;
        longint             cos_val;
        color_t             c;
        diff = $signed({h[31], h}) - $signed({lo[31], lo});
        prod = {{31{diff[32]}}, diff} * {32'd0, span};
        t    = prod[39:0];
        // Phases above one half fold back; exactly one half stays as it is.
        m    = (t > 40'h80_0000_0000) ? (40'd0 - t) : t;
        idx  = 64'(m >> (40 - PHASE_BITS));
        angle = ANGLE_START + longint'((ANGLE_GAIN * idx) >> PHASE_BITS);
        x     = angle - QUARTER_TURN;
        ax    = longint'((x < 0) ? -x : x);
        // sin(angle) = cos(x), cos(angle) = -sin(x).
        sin_val = taylor_sum(ax, 1'b0);
        cos_val = taylor_sum(ax, 1'b1);
        if (x >= 0)
            cos_val = -cos_val;
        c.red   = to_channel(sin_val);
        c.green = to_channel(cos_val);
        c.blue  = to_channel(-sin_val);
        return c;
    endfunction

    always @(posedge clk)
    begin
        color_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_colors.size() == 0)
                begin
                    $error("Unexpected colour: red %0d, green %0d, blue %0d", red, green, blue);
                    errors_seen++;
                end
                else
                begin
                    want = expected_colors.pop_front();
                    if (red !== want.red)
                    begin
                        $error("red: expected %0d, actual %0d", want.red, red);
                        errors_seen++;
                    end
                    if (green !== want.green)
                    begin
                        $error("green: expected %0d, actual %0d", want.green, green);
                        errors_seen++;
                    end
                    if (blue !== want.blue)
                    begin
                        $error("blue: expected %0d, actual %0d", want.blue, blue);
                        errors_seen++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_colors.push_back(predict_color(height, low_edge_q, inverse_span_q));
            if (write_enable)
            begin
                case (cfg_reg_t'(write_index))
                    REG_LOW_EDGE:     low_edge_q     = write_data;
                    REG_INVERSE_SPAN: inverse_span_q = write_data;
                    default:          ;
                endcase
            end
            outstanding = expected_colors.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the height to colour map. The checker beside the
// block does all prediction and comparison; this module only drives requests,
// stalls the result side, loads range registers between phases and reports.
module tb_top;

    import hcm_pkg::*;

    localparam int PHASE_BITS  = 10;
    localparam int WATCHDOG    = 2000;
    localparam int DRAIN_WAIT  = 8;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_LEN   = 125;

    // Every input has a known value from time zero, before any clock edge.
    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic [HEIGHT_W-1:0]   height       = '0;
    logic                  out_stall    = 1'b0;
    logic                  write_enable = 1'b0;
    logic [CFG_IDX_W-1:0]  write_index  = '0;
    logic [CFG_DATA_W-1:0] write_data   = '0;

    logic                  in_stall;
    logic                  out_valid;
    logic [CHAN_W-1:0]     red;
    logic [CHAN_W-1:0]     green;
    logic [CHAN_W-1:0]     blue;

    int                    fail_count;
    int                    pending_results;
    bit                    idle_on      = 1'b0;
    int                    stall_left   = 0;
    int                    quiet_cycles = 0;
    logic [CFG_DATA_W-1:0] low_edge_now = LOW_EDGE_RESET;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    height_to_color_map #(
        .PHASE_BITS (PHASE_BITS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .height       (height),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data)
    );

    color_map_checker #(
        .PHASE_BITS (PHASE_BITS)
    ) i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .height          (height),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .red             (red),
        .green           (green),
        .blue            (blue),
        .write_enable    (write_enable),
        .write_index     (write_index),
        .write_data      (write_data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // The result side stalls in bursts while idling is enabled. A burst is
    // started on a random cycle and then held for its randomly drawn remaining
    // length, so stalls land on every stage of the pipeline.
    always @(negedge clk)
    begin
        if (!idle_on)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 2);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // The watchdog counts cycles in which neither channel moves anything. The
    // longest legal quiet stretch is a few stalls plus the pipeline depth and
    // a register load, so the limit leaves a wide margin.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Offers one request, optionally after a short gap, and returns at the
    // falling edge after the one at which it was accepted. The valid line is
    // only lowered when a gap is actually inserted, so back-to-back requests
    // keep it high without a second assignment in the same step.
    task automatic send_request(input logic [HEIGHT_W-1:0] h);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        height   <= h;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Registers may only change while the block is empty, so every load waits
    // until the checker holds no outstanding colour and the pipeline has had
    // time to settle.
    task automatic load_range(input logic [CFG_DATA_W-1:0] lo,
                              input logic [CFG_DATA_W-1:0] span);
        in_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
        write_enable <= 1'b1;
        write_index  <= REG_LOW_EDGE;
        write_data   <= lo;
        @(negedge clk);
        write_index  <= REG_INVERSE_SPAN;
        write_data   <= span;
        @(negedge clk);
        write_enable <= 1'b0;
        low_edge_now = lo;
    endtask

    // Heights come in equal shares: near the lower edge, near zero, at the two
    // extremes and unconstrained, so the useful part of the range is exercised.
    function automatic logic [HEIGHT_W-1:0] random_height();
        case ($urandom_range(0, 3))
            0:       return low_edge_now + $urandom_range(0, 32'h00FF_FFFF);
            1:       return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
            2:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_low_edge();
        case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
            default: return $urandom;
        endcase
    endfunction

    // Spans range from the extremes and zero to reciprocals of realistic
    // height ranges, where the colour actually sweeps across the ramp.
    function automatic logic [CFG_DATA_W-1:0] random_span();
        case ($urandom_range(0, 5))
            0:       return 32'd1;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'd0;
            3:       return $urandom;
            default: return $urandom_range(1, 32'h0200_0000);
        endcase
    endfunction

    initial
    begin
        // Reset is held from time zero and released on a falling edge.
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, first with the reset range: the height extremes.
        idle_on = 1'b1;
        send_request(32'h0000_0000);
        send_request(32'h7FFF_FFFF);
        send_request(32'h8000_0000);
        send_request(32'hFFFF_FFFF);

        // A span of exactly one maps 0.5 in Q16.16 to a phase of exactly one
        // half, which must not be folded; neighbours check the fold itself.
        load_range(32'h0000_0000, 32'h0100_0000);
        send_request(32'h0000_8000);
        send_request(32'h0000_8001);
        send_request(32'h0000_7FFF);
        send_request(32'h0000_4000);
        send_request(32'h0000_C000);
        send_request(32'h0000_FFFF);
        send_request(32'h0001_0000);

        // Register extremes: the widest difference with the largest span.
        load_range(32'h8000_0000, 32'hFFFF_FFFF);
        send_request(32'h7FFF_FFFF);
        send_request(32'h8000_0000);
        send_request(32'h1234_5678);

        // Highest lower edge with the smallest nonzero span, so the difference is
        // negative and the fraction must come out as x - floor(x).
        load_range(32'h7FFF_FFFF, 32'h0000_0001);
        send_request(32'h8000_0000);
        send_request(32'h7FFF_FFFF);
        send_request(32'h0000_0000);

        // A zero span collapses every height onto the start of the ramp.
        load_range(32'h0000_0000, 32'h0000_0000);
        send_request(32'h1357_9BDF);
        send_request(32'h8000_0000);

        // Random part: a fresh range per phase, idling enabled at random so
        // that some phases run flat out. The final phase never idles.
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            load_range(random_low_edge(), random_span());
            idle_on = (p < RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
            for (int n = 0; n < PHASE_LEN; n++)
                send_request(random_height());
        end

        // Drain: wait for every outstanding colour, then a further drain period in
        // case the block produces anything it should not.
        in_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        if (fail_count == 0 && pending_results == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
design/hcm_pkg.sv
design/hcm_phase.sv
design/hcm_color_rom.sv
design/height_to_color_map.sv
tb/color_map_checker.sv
tb/tb_top.sv
